/* design/sqd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sqd_pkg: shared constants for the shortest queue dispatcher
// Field widths of the job and result transfers and fixed limits.
// ----------------------------------------------------------------------------
package sqd_pkg;

    localparam int ARRIVAL_W  = 32;
    localparam int SERVICE_W  = 24;
    localparam int TIME_W     = 40;
    localparam int WAIT_W     = 28;
    localparam int JOBS_W     = 8;
    localparam int LANE_OUT_W = 3;
    localparam int CFG_W      = 4;

    localparam logic [WAIT_W-1:0] WAIT_MAX        = {WAIT_W{1'b1}};
    localparam logic [CFG_W-1:0]  CFG_LANES_RESET = 4'd8;

endpackage : sqd_pkg
`default_nettype wire

/* design/shortest_queue_dispatcher_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shortest_queue_dispatcher_core: join-shortest-queue job dispatcher
// Keeps a FIFO of finish times per lane and places each job on the lane
// with the fewest queued jobs.
// ----------------------------------------------------------------------------
// A job transfer is accepted when start is high and busy is low. The job then
// runs through a sequencer built around the single read port of the finish
// time store. Retirement visits every lane in turn: an empty lane is passed
// over, each queued entry is read and then compared, an expired entry is
// popped and the next one read, and the first entry that has not expired
// ends the lane. The scan then looks at one lane count per cycle over the
// lanes in use. Then come the tail check, the tail read when the chosen lane
// holds entries, the insertion and the wait update; a full chosen lane ends
// the job at the tail check. The result is presented for exactly one
// cycle with done high; the receiver cannot stall it, so it must take every
// result as it appears. busy falls in the same cycle that done is raised, so
// the next job may be started right then. Configuration writes to
// lanes_in_use must only be made while busy is low.
// ----------------------------------------------------------------------------
module shortest_queue_dispatcher_core
    import sqd_pkg::*;
#(
    parameter int MAX_LANES  = 8,
    parameter int LANE_DEPTH = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write port.
    input  wire logic                  cfg_write_en,
    input  wire logic [CFG_W-1:0]      cfg_write_data,
    // Job command.
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [ARRIVAL_W-1:0]  arrival_time,
    input  wire logic [SERVICE_W-1:0]  service_time,
    // Result strobe and fields.
    output logic                       done,
    output logic [LANE_OUT_W-1:0]      chosen_lane,
    output logic [TIME_W-1:0]          finish_time,
    output logic [WAIT_W-1:0]          job_wait,
    output logic [WAIT_W-1:0]          max_wait_so_far,
    output logic [JOBS_W-1:0]          jobs_in_system,
    output logic [JOBS_W-1:0]          max_jobs_so_far,
    output logic                       lane_full
);

    // Derived sizes. A lane index always has at least one bit.
    localparam int STORE_DEPTH = MAX_LANES * LANE_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int LANE_W      = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
    localparam int HEAD_W      = $clog2(LANE_DEPTH);
    localparam int CNT_W       = $clog2(LANE_DEPTH + 1);
    localparam int OFF_W       = CNT_W + 1;
    localparam int TOT_W       = $clog2(STORE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RET_RD,
        ST_RET_CMP,
        ST_SCAN,
        ST_TAIL,
        ST_TAIL_WAIT,
        ST_CALC,
        ST_WAIT
    } state_t;

    state_t                state_reg;
    logic [CFG_W-1:0]      lanes_in_use_reg;
    logic [LANE_W-1:0]     lane_reg;
    logic [LANE_W-1:0]     best_reg;
    logic [CNT_W-1:0]      best_n_reg;
    logic [HEAD_W-1:0]     head_reg  [MAX_LANES];
    logic [CNT_W-1:0]      count_reg [MAX_LANES];
    logic [TOT_W-1:0]      total_reg;
    logic [TOT_W-1:0]      max_jobs_reg;
    logic [WAIT_W-1:0]     max_wait_reg;
    logic [ARRIVAL_W-1:0]  arrival_reg;
    logic [SERVICE_W-1:0]  service_reg;
    logic [TIME_W-1:0]     start_reg;
    logic [TIME_W-1:0]     finish_reg;
    logic [WAIT_W-1:0]     job_wait_reg;
    logic [LANE_OUT_W-1:0] chosen_lane_reg;
    logic                  lane_full_reg;
    logic                  done_reg;

    // Effective lane count: zero acts as one, anything above MAX_LANES is
    // clamped to MAX_LANES. Compared in eight bits so any MAX_LANES up to 255 fits.
    logic [7:0]        cfg_ext;
    logic [7:0]        used_lanes;
    logic [LANE_W-1:0] last_used;

    assign cfg_ext = {4'b0000, lanes_in_use_reg};

    always_comb
    begin
        if (cfg_ext == 8'd0)
        begin
            used_lanes = 8'd1;
        end
        else if (cfg_ext > 8'(MAX_LANES))
        begin
            used_lanes = 8'(MAX_LANES);
        end
        else
        begin
            used_lanes = cfg_ext;
        end
    end

    assign last_used = LANE_W'(used_lanes - 8'd1);

    // Per-lane view at the lane pointer, which walks the lanes during
    // retirement and the scan and then holds the chosen lane.
    logic [HEAD_W-1:0] head_cur;
    logic [CNT_W-1:0]  count_cur;

    assign head_cur  = head_reg[lane_reg];
    assign count_cur = count_reg[lane_reg];

    // Ring offsets of the tail entry and of the insertion slot. Both sums
    // stay below twice the lane depth, so one conditional subtract wraps them.
    logic [OFF_W-1:0]  tail_sum;
    logic [OFF_W-1:0]  ins_sum;
    logic [HEAD_W-1:0] tail_off;
    logic [HEAD_W-1:0] ins_off;

    assign tail_sum = OFF_W'(head_cur) + OFF_W'(best_n_reg) - OFF_W'(1);
    assign ins_sum  = OFF_W'(head_cur) + OFF_W'(best_n_reg);

    always_comb
    begin
        if (tail_sum >= OFF_W'(LANE_DEPTH))
        begin
            tail_off = HEAD_W'(tail_sum - OFF_W'(LANE_DEPTH));
        end
        else
        begin
            tail_off = HEAD_W'(tail_sum);
        end
        if (ins_sum >= OFF_W'(LANE_DEPTH))
        begin
            ins_off = HEAD_W'(ins_sum - OFF_W'(LANE_DEPTH));
        end
        else
        begin
            ins_off = HEAD_W'(ins_sum);
        end
    end

    // Store addressing: the lane picks a block of LANE_DEPTH entries.
    logic [ADDR_W-1:0] lane_base;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic              wr_en;
    logic [TIME_W-1:0] rd_data;
    logic [TIME_W-1:0] finish_sum;

    assign lane_base  = ADDR_W'(lane_reg) * ADDR_W'(LANE_DEPTH);
    assign rd_addr    = lane_base + ADDR_W'((state_reg == ST_TAIL) ? tail_off : head_cur);
    assign wr_addr    = lane_base + ADDR_W'(ins_off);
    assign rd_en      = (state_reg == ST_RET_RD) || (state_reg == ST_TAIL);
    assign wr_en      = (state_reg == ST_CALC);
    assign finish_sum = start_reg + TIME_W'(service_reg);

    sqd_ram #(
        .WIDTH (TIME_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (finish_sum),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Wait of the placed job: zero if the finish time wrapped below the
    // arrival, saturated to the output range otherwise.
    logic [TIME_W:0]   wait_diff;
    logic [WAIT_W-1:0] wait_val;

    assign wait_diff = {1'b0, finish_reg} - (TIME_W + 1)'(arrival_reg);

    always_comb
    begin
        if (wait_diff[TIME_W])
        begin
            wait_val = '0;
        end
        else if (wait_diff[TIME_W-1:0] > TIME_W'(WAIT_MAX))
        begin
            wait_val = WAIT_MAX;
        end
        else
        begin
            wait_val = wait_diff[WAIT_W-1:0];
        end
    end

    // Scan step: the first lane always seeds the running minimum.
    logic scan_take;

    assign scan_take = (lane_reg == '0) || (count_cur < best_n_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            lanes_in_use_reg <= CFG_LANES_RESET;
            lane_reg         <= '0;
            best_reg         <= '0;
            best_n_reg       <= '0;
            total_reg        <= '0;
            max_jobs_reg     <= '0;
            max_wait_reg     <= '0;
            done_reg         <= 1'b0;
            lane_full_reg    <= 1'b0;
            for (int i = 0; i < MAX_LANES; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_write_en)
            begin
                lanes_in_use_reg <= cfg_write_data;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        arrival_reg <= arrival_time;
                        service_reg <= service_time;
                        lane_reg    <= '0;
                        state_reg   <= ST_RET_RD;
                    end
                end
                ST_RET_RD:
                begin
                    if (count_cur != '0)
                    begin
                        state_reg <= ST_RET_CMP;
                    end
                    else if (lane_reg == LANE_W'(MAX_LANES - 1))
                    begin
                        lane_reg  <= '0;
                        state_reg <= ST_SCAN;
                    end
                    else
                    begin
                        lane_reg <= lane_reg + LANE_W'(1);
                    end
                end
                ST_RET_CMP:
                begin
                    if (rd_data <= TIME_W'(arrival_reg))
                    begin
                        // Oldest entry has finished: pop it and look again.
                        if (head_cur == HEAD_W'(LANE_DEPTH - 1))
                        begin
                            head_reg[lane_reg] <= '0;
                        end
                        else
                        begin
                            head_reg[lane_reg] <= head_cur + HEAD_W'(1);
                        end
                        count_reg[lane_reg] <= count_cur - CNT_W'(1);
                        total_reg           <= total_reg - TOT_W'(1);
                        state_reg           <= ST_RET_RD;
                    end
                    else if (lane_reg == LANE_W'(MAX_LANES - 1))
                    begin
                        lane_reg  <= '0;
                        state_reg <= ST_SCAN;
                    end
                    else
                    begin
                        lane_reg  <= lane_reg + LANE_W'(1);
                        state_reg <= ST_RET_RD;
                    end
                end
                ST_SCAN:
                begin
                    if (scan_take)
                    begin
                        best_reg   <= lane_reg;
                        best_n_reg <= count_cur;
                    end
                    if (lane_reg == last_used)
                    begin
                        lane_reg  <= scan_take ? lane_reg : best_reg;
                        state_reg <= ST_TAIL;
                    end
                    else
                    begin
                        lane_reg <= lane_reg + LANE_W'(1);
                    end
                end
                ST_TAIL:
                begin
                    if (best_n_reg >= CNT_W'(LANE_DEPTH))
                    begin
                        // Chosen lane is full: drop the job, maxima unchanged.
                        chosen_lane_reg <= LANE_OUT_W'(lane_reg);
                        finish_reg      <= '0;
                        job_wait_reg    <= '0;
                        lane_full_reg   <= 1'b1;
                        done_reg        <= 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                    else if (best_n_reg != '0)
                    begin
                        state_reg <= ST_TAIL_WAIT;
                    end
                    else
                    begin
                        start_reg <= TIME_W'(arrival_reg);
                        state_reg <= ST_CALC;
                    end
                end
                ST_TAIL_WAIT:
                begin
                    if (rd_data > TIME_W'(arrival_reg))
                    begin
                        start_reg <= rd_data;
                    end
                    else
                    begin
                        start_reg <= TIME_W'(arrival_reg);
                    end
                    state_reg <= ST_CALC;
                end
                ST_CALC:
                begin
                    finish_reg          <= finish_sum;
                    count_reg[lane_reg] <= best_n_reg + CNT_W'(1);
                    total_reg           <= total_reg + TOT_W'(1);
                    state_reg           <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    chosen_lane_reg <= LANE_OUT_W'(lane_reg);
                    job_wait_reg    <= wait_val;
                    lane_full_reg   <= 1'b0;
                    if (wait_val > max_wait_reg)
                    begin
                        max_wait_reg <= wait_val;
                    end
                    if (total_reg > max_jobs_reg)
                    begin
                        max_jobs_reg <= total_reg;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Occupancy outputs are the low byte of the full-width counters.
    logic [TOT_W+JOBS_W-1:0] total_ext;
    logic [TOT_W+JOBS_W-1:0] max_jobs_ext;

    assign total_ext    = {{JOBS_W{1'b0}}, total_reg};
    assign max_jobs_ext = {{JOBS_W{1'b0}}, max_jobs_reg};

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign chosen_lane     = chosen_lane_reg;
    assign finish_time     = finish_reg;
    assign job_wait        = job_wait_reg;
    assign max_wait_so_far = max_wait_reg;
    assign jobs_in_system  = total_ext[JOBS_W-1:0];
    assign max_jobs_so_far = max_jobs_ext[JOBS_W-1:0];
    assign lane_full       = lane_full_reg;

    // A result is only presented once the sequencer has returned to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result presented while a job is still in progress");

    // A dropped job reports no finish time and no wait.
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && lane_full) |-> (finish_time == '0) && (job_wait == '0))
        else $error("dropped job reports a finish time or wait");

    // The running maximum covers the wait of every placed job.
    a_max_wait: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (max_wait_so_far >= job_wait))
        else $error("running maximum wait below job wait");

    // Retirement only compares entries that the lane counts as queued.
    a_ret_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RET_CMP) |-> (count_cur != '0))
        else $error("retirement read an entry outside the queue");

    // No lane ever holds more than its depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_cur <= CNT_W'(LANE_DEPTH))
        else $error("lane count exceeds lane depth");

endmodule : shortest_queue_dispatcher_core
`default_nettype wire

/* design/sqd_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sqd_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sqd_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule : sqd_ram
`default_nettype wire

/* verif/shortest_queue_dispatcher_core_test.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shortest_queue_dispatcher_core_test: self-checking bench for the dispatcher
// Drives job transfers and lane count writes into the dispatcher, predicts
// every result with an independent model of the lane FIFOs, and compares the
// result transfers field by field as they appear on the done strobe.
// ----------------------------------------------------------------------------
module shortest_queue_dispatcher_core_test
    import sqd_pkg::*;
();

    localparam int LANES_MAX  = 8;
    localparam int FIFO_DEPTH = 16;

    // Highest arrival used by ordinary jobs. Keeping arrivals below it means
    // every queued finish time stays within 32 bits, so a job arriving at the
    // very top of the range can still flush all lanes.
    localparam logic [ARRIVAL_W-1:0] ARRIVAL_CEILING = 32'hE000_0000;

    typedef enum logic [1:0] {
        CMD_JOB,    // one job transfer
        CMD_LANES,  // write lanes_in_use once the block has gone quiet
        CMD_DRAIN   // hold off until every result has come back
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [ARRIVAL_W-1:0]   arrival;
        logic [SERVICE_W-1:0]   service;
        logic [CFG_W-1:0]       lanes;
    } cmd_t;

    typedef struct packed {
        logic [LANE_OUT_W-1:0]  lane;
        logic [TIME_W-1:0]      finish;
        logic [WAIT_W-1:0]      job_wt;
        logic [WAIT_W-1:0]      peak_wait;
        logic [JOBS_W-1:0]      jobs;
        logic [JOBS_W-1:0]      peak_jobs;
        logic                   full;
    } dispatch_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_W-1:0]       cfg_write_data = '0;
    logic                   start = 1'b0;
    logic [ARRIVAL_W-1:0]   arrival_time = '0;
    logic [SERVICE_W-1:0]   service_time = '0;
    logic                   busy;
    logic                   done;
    logic [LANE_OUT_W-1:0]  chosen_lane;
    logic [TIME_W-1:0]      finish_time;
    logic [WAIT_W-1:0]      job_wait;
    logic [WAIT_W-1:0]      max_wait_so_far;
    logic [JOBS_W-1:0]      jobs_in_system;
    logic [JOBS_W-1:0]      max_jobs_so_far;
    logic                   lane_full;

    shortest_queue_dispatcher_core #(
        .MAX_LANES  (LANES_MAX),
        .LANE_DEPTH (FIFO_DEPTH)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .start           (start),
        .busy            (busy),
        .arrival_time    (arrival_time),
        .service_time    (service_time),
        .done            (done),
        .chosen_lane     (chosen_lane),
        .finish_time     (finish_time),
        .job_wait        (job_wait),
        .max_wait_so_far (max_wait_so_far),
        .jobs_in_system  (jobs_in_system),
        .max_jobs_so_far (max_jobs_so_far),
        .lane_full       (lane_full)
    );

    always #1 clk = ~clk;

    // Commands waiting to be driven, and results predicted for jobs that the
    // block has accepted but not yet reported.
    cmd_t       job_backlog[$];
    dispatch_t  awaited_dispatches[$];
    int         mismatches = 0;

    // Sender pacing: a burst of back-to-back transfers, then a gap.
    int         burst_left = 1;
    int         gap_left = 0;

    // Shadow of the dispatcher state: one circular FIFO of finish times per
    // lane, with a head pointer and an occupancy count.
    logic [TIME_W-1:0]  lane_fin[LANES_MAX][FIFO_DEPTH];
    int                 lane_head[LANES_MAX];
    int                 lane_cnt[LANES_MAX];
    int                 jobs_total = 0;
    int                 peak_jobs = 0;
    logic [63:0]        peak_wait = '0;
    logic [CFG_W-1:0]   lanes_cfg = CFG_LANES_RESET;

    initial
    begin
        for (int i = 0; i < LANES_MAX; i++)
        begin
            lane_head[i] = 0;
            lane_cnt[i]  = 0;
        end
    end

    // Places one job in the shadow state and returns the result the block
    // should report for it.
    function automatic dispatch_t dispatch_job(input logic [ARRIVAL_W-1:0] arr,
                                               input logic [SERVICE_W-1:0] svc);
        dispatch_t   r;
        int          used;
        int          ln;
        int          best;
        int          best_n;
        logic [63:0] start_at;
        logic [63:0] fin;
        logic [63:0] wt;
        used = (lanes_cfg == 0) ? 1 : ((lanes_cfg > LANES_MAX) ? LANES_MAX : int'(lanes_cfg));
        // Retirement runs over every lane, including lanes no longer in use.
        for (ln = 0; ln < LANES_MAX; ln++)
        begin
            while (lane_cnt[ln] > 0 && lane_fin[ln][lane_head[ln]] <= arr)
            begin
                lane_head[ln] = (lane_head[ln] + 1) % FIFO_DEPTH;
                lane_cnt[ln]--;
                if (jobs_total > 0)
                    jobs_total--;
            end
        end
        best   = 0;
        best_n = lane_cnt[0];
        for (ln = 1; ln < used; ln++)
        begin
            if (lane_cnt[ln] < best_n)
            begin
                best_n = lane_cnt[ln];
                best   = ln;
            end
        end
        fin = '0;
        wt  = '0;
        r.full = (best_n >= FIFO_DEPTH);
        if (!r.full)
        begin
            start_at = 64'(arr);
            if (best_n > 0 &&
                lane_fin[best][(lane_head[best] + best_n - 1) % FIFO_DEPTH] > start_at)
                start_at = 64'(lane_fin[best][(lane_head[best] + best_n - 1) % FIFO_DEPTH]);
            fin = (start_at + 64'(svc)) & 64'hFF_FFFF_FFFF;
            lane_fin[best][(lane_head[best] + best_n) % FIFO_DEPTH] = fin[TIME_W-1:0];
            lane_cnt[best]++;
            jobs_total++;
            wt = (fin >= 64'(arr)) ? fin - 64'(arr) : 64'd0;
            if (wt > 64'(WAIT_MAX))
                wt = 64'(WAIT_MAX);
            if (wt > peak_wait)
                peak_wait = wt;
            if (jobs_total > peak_jobs)
                peak_jobs = jobs_total;
        end
        r.lane      = LANE_OUT_W'(best);
        r.finish    = fin[TIME_W-1:0];
        r.job_wt    = wt[WAIT_W-1:0];
        r.peak_wait = peak_wait[WAIT_W-1:0];
        r.jobs      = JOBS_W'(jobs_total);
        r.peak_jobs = JOBS_W'(peak_jobs);
        return r;
    endfunction

    // Driver. A start that is not yet taken is held with its payload; a lane
    // count write is only issued once no job is in flight and is applied to
    // the shadow state at the edge where the block takes it.
    always @(posedge clk)
    begin
        logic keep_start;
        cmd_t cmd;
        if (rst_n)
        begin
            keep_start = start && busy;
            if (start && !busy)
                awaited_dispatches.insert(awaited_dispatches.size(),
                                          dispatch_job(arrival_time, service_time));
            if (cfg_write_en)
            begin
                lanes_cfg = cfg_write_data;
                cfg_write_en <= 1'b0;
            end
            else if (!keep_start && job_backlog.size() > 0)
            begin
                cmd = job_backlog[0];
                if (cmd.kind == CMD_JOB)
                begin
                    if (gap_left > 0)
                    begin
                        gap_left--;
                    end
                    else
                    begin
                        job_backlog.delete(0);
                        arrival_time <= cmd.arrival;
                        service_time <= cmd.service;
                        keep_start = 1'b1;
                        burst_left--;
                        if (burst_left <= 0)
                        begin
                            burst_left = int'($urandom_range(1, 40));
                            gap_left = ($urandom_range(0, 3) == 0) ?
                                       0 : int'($urandom_range(1, 30));
                        end
                    end
                end
                else if (!start && !busy && awaited_dispatches.size() == 0)
                begin
                    // The block is quiet: every result has been reported.
                    job_backlog.delete(0);
                    if (cmd.kind == CMD_LANES)
                    begin
                        cfg_write_en   <= 1'b1;
                        cfg_write_data <= cmd.lanes;
                    end
                end
            end
            start <= keep_start;
        end
    end

    task automatic compare_field(input string fname, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            mismatches++;
        end
    endtask

    // Monitor. Results cannot be held off, so every done cycle is taken.
    always @(posedge clk)
    begin
        dispatch_t want;
        if (rst_n && done)
        begin
            if (awaited_dispatches.size() == 0)
            begin
                $display("%0t: result transfer with no job outstanding, lane %0d finish %0h",
                         $time, chosen_lane, finish_time);
                mismatches++;
            end
            else
            begin
                want = awaited_dispatches[0];
                awaited_dispatches.delete(0);
                compare_field("chosen_lane", want.lane, chosen_lane);
                compare_field("finish_time", want.finish, finish_time);
                compare_field("job_wait", want.job_wt, job_wait);
                compare_field("max_wait_so_far", want.peak_wait, max_wait_so_far);
                compare_field("jobs_in_system", want.jobs, jobs_in_system);
                compare_field("max_jobs_so_far", want.peak_jobs, max_jobs_so_far);
                compare_field("lane_full", want.full, lane_full);
            end
        end
    end

    task automatic add_job(input logic [ARRIVAL_W-1:0] arr, input logic [SERVICE_W-1:0] svc);
        cmd_t c;
        c = '{CMD_JOB, arr, svc, '0};
        job_backlog.insert(job_backlog.size(), c);
    endtask

    task automatic add_lanes(input logic [CFG_W-1:0] lanes);
        cmd_t c;
        c = '{CMD_LANES, '0, '0, lanes};
        job_backlog.insert(job_backlog.size(), c);
    endtask

    task automatic add_drain();
        cmd_t c;
        c = '{CMD_DRAIN, '0, '0, '0};
        job_backlog.insert(job_backlog.size(), c);
    endtask

    // Stimulus, then the end of the run.
    initial
    begin
        logic [ARRIVAL_W-1:0] arr_now;
        logic [SERVICE_W-1:0] svc;
        logic [63:0]          step;
        int                   jobs_made;
        int                   phase;
        int                   phase_len;
        int                   sc;
        int                   sb;
        int                   pick;

        // Directed part, with the reset lane count of eight. The first job
        // finishes on arrival and is retired by the next one; the others
        // spread over lanes 0 to 2 by the lowest-index tie rule.
        add_job(32'd0, 24'd0);
        add_job(32'd0, 24'hFF_FFFF);
        add_job(32'd0, 24'd5);
        add_job(32'd0, 24'hFF_FFFF);
        // A lane count of zero acts as one lane. Lane 2 keeps an entry that
        // is outside the lanes in use yet still counts in the system total.
        // Lane 0 fills to its depth with maximal service, so the last two
        // jobs are dropped as full.
        add_lanes(4'd0);
        repeat (17) add_job(32'd1000, 24'hFF_FFFF);
        // One lane again: flush everything, then an arrival that goes
        // backwards behind a long tail so that the wait saturates.
        add_lanes(4'd1);
        add_job(32'h1000_0000, 24'hFF_FFFF);
        add_job(32'd0, 24'hFF_FFFF);
        add_job(32'hFFFF_FFFF, 24'd0);

        // Random part, in phases that each start with a lane count write.
        // Within a phase the arrival and service scales are fixed, so that
        // some phases keep the lanes nearly empty and others overflow them.
        arr_now   = '0;
        jobs_made = 0;
        phase     = 0;
        while (jobs_made < 1750)
        begin
            case (phase)
                0:       add_lanes(4'd8);
                1:       add_lanes(4'd1);
                2:       add_lanes(4'd15);
                3:       add_lanes(4'd0);
                4:       add_lanes(4'd2);
                default: add_lanes(CFG_W'($urandom_range(0, 15)));
            endcase
            sc = int'($urandom_range(4, 22));
            sb = sc + int'($urandom_range(0, 8));
            if (sb > SERVICE_W)
                sb = SERVICE_W;
            phase_len = int'($urandom_range(80, 180));
            for (int k = 0; k < phase_len; k++)
            begin
                if (k == phase_len / 2 && $urandom_range(0, 2) == 0)
                    add_drain();
                pick = int'($urandom_range(0, 99));
                if (pick < 2)
                    arr_now = $urandom_range(0, ARRIVAL_CEILING - 1);  // may go backwards
                else if (pick < 4)
                    step = 64'($urandom_range(0, 32'h4000_0000));
                else if (pick < 30)
                    step = 64'd0;
                else
                    step = 64'($urandom_range(0, (1 << sc) - 1));
                if (pick >= 2)
                begin
                    if (arr_now + step >= ARRIVAL_CEILING)
                    begin
                        // Top of the time range: one job at the largest
                        // arrival retires everything, then time restarts low.
                        add_job(32'hFFFF_FFFF, 24'd0);
                        jobs_made++;
                        arr_now = $urandom_range(0, 32'h000F_FFFF);
                    end
                    else
                    begin
                        arr_now = arr_now + step[ARRIVAL_W-1:0];
                    end
                end
                pick = int'($urandom_range(0, 99));
                if (pick < 5)
                    svc = '0;
                else if (pick < 10)
                    svc = 24'hFF_FFFF;
                else if (pick < 20)
                    svc = SERVICE_W'($urandom());
                else
                    svc = SERVICE_W'($urandom_range(0, (1 << sb) - 1));
                add_job(arr_now, svc);
                jobs_made++;
            end
            phase++;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Checked away from the active edge, once every update has settled.
        while (job_backlog.size() > 0 || start || busy || cfg_write_en ||
               awaited_dispatches.size() > 0)
            @(negedge clk);
        // Any stray result after the last one would show up here.
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus.
    initial
    begin
        #20000000;
        $display("%0t: timeout with %0d results outstanding", $time,
                 awaited_dispatches.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule : shortest_queue_dispatcher_core_test
`default_nettype wire
